FILE: design/pcmmix_pkg.sv
package pcmmix_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int COUNT_BITS   = 20;
   localparam int PAD_SAMPLES  = 32;
   localparam int TERM_BITS    = 9;
   localparam int SUM_BITS     = TERM_BITS + $clog2(NUM_CHANNELS + 1);

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2,
      OP_SETVOL = 2'd3
   } op_type;

   typedef logic signed [TERM_BITS-1:0] term_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  channel;
      logic [6:0]  volume;
      logic [19:0] header_count;
      logic [7:0]  sample_0;
      logic [7:0]  sample_1;
      logic [7:0]  sample_2;
      logic [7:0]  sample_3;
      logic [7:0]  sample_4;
      logic [7:0]  sample_5;
      logic [7:0]  sample_6;
      logic [7:0]  sample_7;
   } req_type;

   typedef struct packed {
      logic [7:0] mixed_sample;
      logic [7:0] consumed_mask;
      logic [7:0] playing_mask;
      logic       start_accepted;
   } rsp_type;

   // decoded command shared by all lanes
   typedef struct packed {
      logic                  accept;
      logic                  load2;
      logic                  tick_en;
      logic                  start_ok;
      logic                  stop;
      logic                  setvol;
      logic [6:0]            volume;
      logic [COUNT_BITS-1:0] length;
   } ctl_type;

endpackage

FILE: design/pcmmix_lane.sv
module pcmmix_lane (
   input  logic               clock,
   input  logic               reset,
   input  pcmmix_pkg::ctl_type ctl,
   input  logic               select,
   input  logic [7:0]         sample,
   output logic               active,
   output logic               active_next,
   output logic               consume,
   output pcmmix_pkg::term_type term
);
   import pcmmix_pkg::*;

   logic                  active_ff, active_in;
   logic [COUNT_BITS-1:0] position_ff, position_in;
   logic [COUNT_BITS-1:0] length_ff, length_in;
   logic [6:0]            volume_ff, volume_in;
   logic [14:0]           prod_ff, prod_in;
   logic                  neg_ff;
   term_type              term_ff, term_in;
   logic [COUNT_BITS-1:0] pos_inc;
   logic [7:0]            mag;
   logic [14:0]           div_sum;
   logic [7:0]            quot;

   assign consume = ctl.tick_en && active_ff;
   assign pos_inc = position_ff + COUNT_BITS'(1);

   // channel state update for the accepted word
   always_comb begin
      active_in   = active_ff;
      position_in = position_ff;
      length_in   = length_ff;
      volume_in   = volume_ff;
      if (ctl.accept) begin
         if (consume) begin
            position_in = pos_inc;
            if (pos_inc >= length_ff) begin
               active_in = 1'b0;
            end
         end
         if (ctl.start_ok && select) begin
            length_in   = ctl.length;
            position_in = '0;
            volume_in   = ctl.volume;
            active_in   = 1'b1;
         end
         if (ctl.stop && select) begin
            active_in = 1'b0;
         end
         if (ctl.setvol && select) begin
            volume_in = ctl.volume;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         position_ff <= '0;
         length_ff   <= '0;
         volume_ff   <= '0;
      end else begin
         active_ff   <= active_in;
         position_ff <= position_in;
         length_ff   <= length_in;
         volume_ff   <= volume_in;
      end
   end

   // magnitude of the offset-binary sample, then scale by volume
   assign mag     = sample[7] ? {1'b0, sample[6:0]} : 8'(8'd128 - sample);
   assign prod_in = consume ? 15'(mag) * 15'(volume_ff) : '0;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         prod_ff <= prod_in;
         neg_ff  <= ~sample[7];
      end
   end

   // divide by 127: exact for products up to 127 * 128
   assign div_sum = prod_ff + (prod_ff >> 7) + 15'd1;
   assign quot    = div_sum[14:7];
   assign term_in = neg_ff ? -term_type'({1'b0, quot}) : term_type'({1'b0, quot});

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         term_ff <= term_in;
      end
   end

   assign active      = active_ff;
   assign active_next = active_in;
   assign term        = term_ff;

endmodule

FILE: design/pcmmix_merge.sv
module pcmmix_merge (
   input  pcmmix_pkg::term_type terms [pcmmix_pkg::NUM_CHANNELS],
   output logic [7:0]           mixed
);
   import pcmmix_pkg::*;

   logic signed [SUM_BITS-1:0] sum;
   logic signed [SUM_BITS-1:0] clamped;

   // add the lane terms
   always_comb begin
      sum = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sum = sum + SUM_BITS'(terms[c]);
      end
   end

   // clamp to the signed byte range, then shift back to unsigned
   always_comb begin
      clamped = sum;
      if (sum > SUM_BITS'(127)) begin
         clamped = SUM_BITS'(127);
      end else if (sum < -SUM_BITS'(128)) begin
         clamped = -SUM_BITS'(128);
      end
   end

   assign mixed = clamped[7:0] ^ 8'h80;

endmodule

FILE: design/multichannel_pcm_mixer.sv
// Path: a result word passes the product, divided-term and output registers after its request is accepted.
// Throughput: one word per cycle unless rsp_stall holds the pipeline; lane state
// updates in the accept cycle, so each word sees the previous one's effect with no wait.
// The three-register pipeline (product, divided term, output) holds on rsp_stall.
// Reset (synchronous, active high) clears enable, all channel state and all valids.
module multichannel_pcm_mixer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pcmmix_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pcmmix_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data
);
   import pcmmix_pkg::*;

   logic                  enable_ff, enable_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  load_out, load2, accept;
   logic                  s1_free, s2_free, out_free;
   logic [COUNT_BITS-1:0] count;
   logic                  valid_ch;
   ctl_type               ctl;
   logic [7:0]            sample_arr [8];
   logic [7:0]            consumed_now, playing_now, active_now;
   term_type              terms [NUM_CHANNELS];
   logic [7:0]            mixed;
   logic [7:0]            s1_consumed_ff, s1_playing_ff;
   logic                  s1_started_ff;
   logic [7:0]            s2_consumed_ff, s2_playing_ff;
   logic                  s2_started_ff;
   rsp_type               rsp_ff;

   // configuration register
   assign csr_ready = 1'b1;
   assign enable_in = (csr_valid && csr_ready) ? csr_data : enable_ff;

   // pipeline flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || load_out;
   assign load2     = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || load2;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   assign s1_valid_in  = accept || (s1_valid_ff && !load2);
   assign s2_valid_in  = load2 || (s2_valid_ff && !load_out);
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // decode the request word
   assign count    = COUNT_BITS'(req_data.header_count);
   assign valid_ch = 4'(req_data.channel) < 4'(NUM_CHANNELS);

   always_comb begin
      ctl.accept   = accept;
      ctl.load2    = load2;
      ctl.tick_en  = (req_data.op == OP_TICK) && enable_ff;
      ctl.start_ok = (req_data.op == OP_START) && enable_ff && valid_ch
                     && (count > COUNT_BITS'(PAD_SAMPLES));
      ctl.stop     = (req_data.op == OP_STOP);
      ctl.setvol   = (req_data.op == OP_SETVOL);
      ctl.volume   = req_data.volume;
      ctl.length   = count - COUNT_BITS'(PAD_SAMPLES);
   end

   assign sample_arr[0] = req_data.sample_0;
   assign sample_arr[1] = req_data.sample_1;
   assign sample_arr[2] = req_data.sample_2;
   assign sample_arr[3] = req_data.sample_3;
   assign sample_arr[4] = req_data.sample_4;
   assign sample_arr[5] = req_data.sample_5;
   assign sample_arr[6] = req_data.sample_6;
   assign sample_arr[7] = req_data.sample_7;

   // one lane per channel
   for (genvar c = 0; c < 8; c++) begin : g_lane
      if (c < NUM_CHANNELS) begin : g_on
         pcmmix_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .select      (req_data.channel == 3'(c)),
            .sample      (sample_arr[c]),
            .active      (active_now[c]),
            .active_next (playing_now[c]),
            .consume     (consumed_now[c]),
            .term        (terms[c])
         );
      end else begin : g_off
         assign active_now[c]   = 1'b0;
         assign playing_now[c]  = 1'b0;
         assign consumed_now[c] = 1'b0;
      end
   end

   pcmmix_merge u_merge (
      .terms (terms),
      .mixed (mixed)
   );

   // carry the per-word masks alongside the lane pipeline
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_consumed_ff <= consumed_now;
         s1_playing_ff  <= playing_now;
         s1_started_ff  <= ctl.start_ok;
      end
      if (load2) begin
         s2_consumed_ff <= s1_consumed_ff;
         s2_playing_ff  <= s1_playing_ff;
         s2_started_ff  <= s1_started_ff;
      end
      if (load_out) begin
         rsp_ff.mixed_sample   <= mixed;
         rsp_ff.consumed_mask  <= s2_consumed_ff;
         rsp_ff.playing_mask   <= s2_playing_ff;
         rsp_ff.start_accepted <= s2_started_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_idle_mix_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.consumed_mask == 8'd0) |-> rsp_ff.mixed_sample == 8'h80)
      else $error("mixed word not silent with no channel consumed");

   a_start_no_consume: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.start_accepted |-> rsp_ff.consumed_mask == 8'd0)
      else $error("start word reports consumed samples");

   a_tick_consumes_active: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.op == OP_TICK) && enable_ff
      |=> s1_consumed_ff == $past(active_now))
      else $error("enabled tick did not consume every playing channel");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(active_now))
      else $error("channel state changed without an accepted word");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !load2 |-> req_stall)
      else $error("request taken while first stage is held");
`endif

endmodule

FILE: dv/tb_multichannel_pcm_mixer.sv
module tb_multichannel_pcm_mixer;
   import pcmmix_pkg::*;

   localparam int FULL_SCALE   = 127;
   localparam int MID_CODE     = 128;
   localparam int LONG_HOLD    = 80;
   localparam int SETTLE_WAIT  = 8;
   localparam int CYCLE_LIMIT  = 200000;

   // Mixer state mirror and queue of expected result words
   class mixer_scoreboard;
      bit                    enable;
      logic [COUNT_BITS-1:0] position [NUM_CHANNELS];
      logic [COUNT_BITS-1:0] length [NUM_CHANNELS];
      logic [6:0]            volume [NUM_CHANNELS];
      bit                    playing [NUM_CHANNELS];
      rsp_type               expected_q[$];
      int                    errors;

      function new();
         enable = 1'b0;
         errors = 0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            position[c] = '0;
            length[c]   = '0;
            volume[c]   = '0;
            playing[c]  = 1'b0;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Apply one accepted request word and queue the result it causes
      function void note_request(req_type w);
         logic [7:0] smp [NUM_CHANNELS];
         rsp_type    r;
         int         mix_sum;
         int         term;
         int         ch;
         smp[0] = w.sample_0;
         smp[1] = w.sample_1;
         smp[2] = w.sample_2;
         smp[3] = w.sample_3;
         smp[4] = w.sample_4;
         smp[5] = w.sample_5;
         smp[6] = w.sample_6;
         smp[7] = w.sample_7;
         ch = int'(w.channel);
         r = '0;
         r.mixed_sample = 8'(MID_CODE);
         case (w.op)
            OP_TICK: begin
               if (enable) begin
                  mix_sum = 0;
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     if (playing[c]) begin
                        term = ((int'(smp[c]) - MID_CODE) * int'(volume[c])) / FULL_SCALE;
                        mix_sum += term;
                        r.consumed_mask[c] = 1'b1;
                        position[c] = position[c] + 1'b1;
                        if (position[c] >= length[c])
                           playing[c] = 1'b0;
                     end
                  end
                  if (mix_sum > FULL_SCALE)
                     mix_sum = FULL_SCALE;
                  if (mix_sum < -MID_CODE)
                     mix_sum = -MID_CODE;
                  r.mixed_sample = 8'(mix_sum + MID_CODE);
               end
            end
            OP_START: begin
               if (enable && ch < NUM_CHANNELS && int'(w.header_count) > PAD_SAMPLES) begin
                  length[ch]   = COUNT_BITS'(int'(w.header_count) - PAD_SAMPLES);
                  position[ch] = '0;
                  volume[ch]   = w.volume;
                  playing[ch]  = 1'b1;
                  r.start_accepted = 1'b1;
               end
            end
            OP_STOP: begin
               if (ch < NUM_CHANNELS)
                  playing[ch] = 1'b0;
            end
            default: begin
               if (ch < NUM_CHANNELS)
                  volume[ch] = w.volume;
            end
         endcase
         for (int c = 0; c < NUM_CHANNELS; c++)
            r.playing_mask[c] = playing[c];
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_val, act_val);
         end
      endfunction

      // Compare one accepted result word with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type exp_word;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none actual %h",
                     $time, got);
            return;
         end
         exp_word = expected_q.pop_front();
         compare_field("mixed_sample", exp_word.mixed_sample, got.mixed_sample);
         compare_field("consumed_mask", exp_word.consumed_mask, got.consumed_mask);
         compare_field("playing_mask", exp_word.playing_mask, got.playing_mask);
         compare_field("start_accepted", exp_word.start_accepted, got.start_accepted);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   mixer_scoreboard mix_sb = new();

   bit idle_on  = 1'b1;
   bit stall_on = 1'b1;
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;

   multichannel_pcm_mixer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Observe handshakes on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            mix_sb.note_request(req_data);
         if (rsp_valid && !rsp_stall)
            mix_sb.check_result(rsp_data);
         if (csr_valid && csr_ready)
            mix_sb.enable = csr_data;
      end
   end

   // Drive result stall: random single stalls, or a long counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= stall_on && ($urandom_range(99) < 6);
      end
   end

   // Stop a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** multichannel_pcm_mixer: FAILED **");
      $finish;
   end

   // Offer one request word, with an occasional one-cycle gap ahead of it
   task automatic send_word(req_type w);
      if (idle_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold the input until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mix_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_enable(logic value);
      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_word(op_type op, int ch, int vol, int count,
                                         logic [7:0] smp);
      req_type w;
      w = '0;
      w.op           = op;
      w.channel      = 3'(ch);
      w.volume       = 7'(vol);
      w.header_count = 20'(count);
      w.sample_0 = smp;
      w.sample_1 = smp;
      w.sample_2 = smp;
      w.sample_3 = smp;
      w.sample_4 = smp;
      w.sample_5 = smp;
      w.sample_6 = smp;
      w.sample_7 = smp;
      return w;
   endfunction

   // Random words: mostly ticks and short starts so channels run out and restart
   task automatic run_random(int n_words, int hold_at);
      req_type    w;
      int         pick;
      logic [7:0] lo_hi;
      for (int i = 0; i < n_words; i++) begin
         if (i == hold_at)
            hold_asked++;
         w = req_type'({$urandom, $urandom, $urandom});
         pick = $urandom_range(99);
         if (pick < 55)
            w.op = OP_TICK;
         else if (pick < 75)
            w.op = OP_START;
         else if (pick < 85)
            w.op = OP_STOP;
         else
            w.op = OP_SETVOL;
         if (w.op == OP_START) begin
            pick = $urandom_range(99);
            if (pick < 70)
               w.header_count = 20'($urandom_range(PAD_SAMPLES + 1, 80));
            else if (pick < 80)
               w.header_count = 20'($urandom_range(0, PAD_SAMPLES));
            else if (pick < 90)
               w.header_count = 20'($urandom_range(81, 4000));
         end
         if (w.op != OP_TICK && $urandom_range(9) < 3)
            w.volume = ($urandom_range(1) != 0) ? 7'(FULL_SCALE) : 7'd0;
         // Drive all lanes hard toward one rail to exercise clamping
         if (w.op == OP_TICK && $urandom_range(3) == 0) begin
            lo_hi = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            w.sample_0 = lo_hi;
            w.sample_1 = lo_hi;
            w.sample_2 = lo_hi;
            w.sample_3 = lo_hi;
            w.sample_4 = lo_hi;
            w.sample_5 = lo_hi;
            w.sample_6 = lo_hi;
            w.sample_7 = lo_hi;
         end
         send_word(w);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Disabled after reset: silent tick, rejected start, stop and volume still act
      send_word(make_word(OP_TICK, 0, 0, 0, 8'hFF));
      send_word(make_word(OP_START, 0, FULL_SCALE, 100, 8'h00));
      send_word(make_word(OP_STOP, 3, 0, 0, 8'h00));
      send_word(make_word(OP_SETVOL, 2, 5, 0, 8'h00));

      write_enable(1'b1);
      send_word(make_word(OP_START, 0, FULL_SCALE, PAD_SAMPLES + 1, 8'h00));
      send_word(make_word(OP_START, 7, FULL_SCALE, 20'hFFFFF, 8'h00));
      send_word(make_word(OP_START, 1, FULL_SCALE, PAD_SAMPLES, 8'h00));
      send_word(make_word(OP_START, 2, FULL_SCALE, 0, 8'h00));
      send_word(make_word(OP_TICK, 0, 0, 0, 8'hFF));
      send_word(make_word(OP_START, 3, FULL_SCALE, PAD_SAMPLES + 2, 8'h00));
      send_word(make_word(OP_TICK, 0, 0, 0, 8'h00));
      send_word(make_word(OP_SETVOL, 7, 0, 0, 8'h00));
      send_word(make_word(OP_TICK, 0, 0, 0, 8'h80));
      send_word(make_word(OP_START, 7, 64, 40, 8'h00));
      send_word(make_word(OP_TICK, 0, 0, 0, 8'h81));
      send_word(make_word(OP_TICK, 0, 0, 0, 8'h7F));
      send_word(make_word(OP_STOP, 7, 0, 0, 8'h00));
      send_word(make_word(OP_STOP, 3, 0, 0, 8'h00));
      send_word(make_word(OP_SETVOL, 5, FULL_SCALE, 0, 8'h00));
      send_word(make_word(OP_TICK, 0, 0, 0, 8'hFF));

      // Random phases across enable settings, one stretch with no idling at all
      write_enable(1'b1);
      run_random(400, -1);
      idle_on  = 1'b0;
      stall_on = 1'b0;
      write_enable(1'b1);
      run_random(250, 20);
      idle_on  = 1'b1;
      stall_on = 1'b1;
      write_enable(1'b0);
      run_random(100, -1);
      write_enable(1'b1);
      run_random(400, -1);

      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mix_sb.errors == 0 && mix_sb.pending() == 0) begin
         $display("** multichannel_pcm_mixer: PASSED **");
      end else begin
         if (mix_sb.pending() != 0)
            $display("%0t: expected result words left over, expected 0 actual %0d",
                     $time, mix_sb.pending());
         $display("** multichannel_pcm_mixer: FAILED **");
      end
      $finish;
   end

endmodule
